FILE: hw/rtl/fsip_pkg.sv
// ----------------------------------------------------------------------------
// fsip_pkg: shared types and constants of the integer format printer
// Word size, digit counts, radix codes, state encodings and ASCII codes used
// by the control path and the digit engine.
// ----------------------------------------------------------------------------
package fsip_pkg;

    localparam int WORD_BITS = 32;

    // Decimal digits of the largest word: floor(WORD_BITS * log10(2)) + 1.
    localparam int NDEC  = ((WORD_BITS * 1233) >> 12) + 1;
    localparam int NOCT  = (WORD_BITS + 2) / 3;
    localparam int NHEX  = (WORD_BITS + 3) / 4;
    // Digit shift register width: holds the BCD result and any aligned word.
    localparam int SR_W  = 4 * NDEC;
    localparam int CNT_W = $clog2(WORD_BITS + 1);

    localparam int SHIFT_BIN = SR_W - WORD_BITS;
    localparam int SHIFT_OCT = SR_W - 3 * NOCT;
    localparam int SHIFT_HEX = SR_W - 4 * NHEX;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        RADIX_BIN,
        RADIX_OCT,
        RADIX_DEC,
        RADIX_HEX_LO,
        RADIX_HEX_UP
    } radix_t;

    typedef struct packed {
        word_t  value;
        radix_t radix;
    } num_cmd_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } num_beat_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_DISPATCH,
        CTRL_NUMBER
    } ctrl_state_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_DABBLE,
        ENG_DIGITS
    } eng_state_t;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UC_A    = 8'h41;
    localparam logic [7:0] CHAR_UC_X    = 8'h58;
    localparam logic [7:0] CHAR_LC_A    = 8'h61;
    localparam logic [7:0] CHAR_LC_B    = 8'h62;
    localparam logic [7:0] CHAR_LC_C    = 8'h63;
    localparam logic [7:0] CHAR_LC_D    = 8'h64;
    localparam logic [7:0] CHAR_LC_O    = 8'h6F;
    localparam logic [7:0] CHAR_LC_U    = 8'h75;
    localparam logic [7:0] CHAR_LC_X    = 8'h78;

endpackage

FILE: hw/rtl/fsip_num_engine.sv
// ----------------------------------------------------------------------------
// fsip_num_engine: digit-serial number to ASCII converter
// Decimal values go through a bit-serial double-dabble into BCD; all radices
// then shift out one digit per cycle while the output is not stalled, most
// significant first, with leading zeros dropped.
// ----------------------------------------------------------------------------
module fsip_num_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  fsip_pkg::num_cmd_t  cmd,
    output logic                beat_valid,
    input  logic                beat_ready,
    output fsip_pkg::num_beat_t beat
);

    fsip_pkg::eng_state_t        state_reg, state_next;
    logic [fsip_pkg::SR_W-1:0]   digit_reg, digit_next;
    fsip_pkg::word_t             bin_reg, bin_next;
    logic [fsip_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    fsip_pkg::radix_t            radix_reg, radix_next;
    logic                        started_reg, started_next;

    logic [3:0]                  cur_digit;
    logic                        show;
    logic                        step;
    logic                        cnt_one;
    logic [fsip_pkg::SR_W-1:0]   dabbled;
    logic [fsip_pkg::SR_W-1:0]   digit_shifted;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? fsip_pkg::CHAR_UC_A : fsip_pkg::CHAR_LC_A;
        if (d < 4'd10)
        begin
            digit_char = fsip_pkg::CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

    // Add-3 correction on every BCD digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < fsip_pkg::NDEC; i++)
        begin
            if (digit_reg[4*i +: 4] >= 4'd5)
            begin
                dabbled[4*i +: 4] = digit_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                dabbled[4*i +: 4] = digit_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        unique case (radix_reg)
            fsip_pkg::RADIX_BIN:
            begin
                cur_digit     = {3'd0, digit_reg[fsip_pkg::SR_W-1]};
                digit_shifted = digit_reg << 1;
            end
            fsip_pkg::RADIX_OCT:
            begin
                cur_digit     = {1'b0, digit_reg[fsip_pkg::SR_W-1 -: 3]};
                digit_shifted = digit_reg << 3;
            end
            default:
            begin
                cur_digit     = digit_reg[fsip_pkg::SR_W-1 -: 4];
                digit_shifted = digit_reg << 4;
            end
        endcase
    end

    assign cnt_one = (cnt_reg == fsip_pkg::CNT_W'(1));
    // The final digit is always shown so that zero prints as a single '0'.
    assign show    = (cur_digit != 4'd0) || started_reg || cnt_one;
    assign step    = (state_reg == fsip_pkg::ENG_DIGITS) && (!show || beat_ready);

    // Outputs.
    always_comb
    begin
        cmd_ready  = (state_reg == fsip_pkg::ENG_IDLE);
        beat_valid = (state_reg == fsip_pkg::ENG_DIGITS) && show;
        beat.ch    = digit_char(cur_digit, radix_reg == fsip_pkg::RADIX_HEX_UP);
        beat.last  = cnt_one;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fsip_pkg::ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.radix == fsip_pkg::RADIX_DEC) ?
                                 fsip_pkg::ENG_DABBLE : fsip_pkg::ENG_DIGITS;
                end
            end
            fsip_pkg::ENG_DABBLE:
            begin
                if (cnt_one)
                begin
                    state_next = fsip_pkg::ENG_DIGITS;
                end
            end
            fsip_pkg::ENG_DIGITS:
            begin
                if (step && cnt_one)
                begin
                    state_next = fsip_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = fsip_pkg::ENG_IDLE;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        digit_next   = digit_reg;
        bin_next     = bin_reg;
        cnt_next     = cnt_reg;
        radix_next   = radix_reg;
        started_next = started_reg;
        unique case (state_reg)
            fsip_pkg::ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    radix_next   = cmd.radix;
                    started_next = 1'b0;
                    bin_next     = cmd.value;
                    unique case (cmd.radix)
                        fsip_pkg::RADIX_BIN:
                        begin
                            digit_next = fsip_pkg::SR_W'(cmd.value) << fsip_pkg::SHIFT_BIN;
                            cnt_next   = fsip_pkg::CNT_W'(fsip_pkg::WORD_BITS);
                        end
                        fsip_pkg::RADIX_OCT:
                        begin
                            digit_next = fsip_pkg::SR_W'(cmd.value) << fsip_pkg::SHIFT_OCT;
                            cnt_next   = fsip_pkg::CNT_W'(fsip_pkg::NOCT);
                        end
                        fsip_pkg::RADIX_DEC:
                        begin
                            digit_next = '0;
                            cnt_next   = fsip_pkg::CNT_W'(fsip_pkg::WORD_BITS);
                        end
                        default:
                        begin
                            digit_next = fsip_pkg::SR_W'(cmd.value) << fsip_pkg::SHIFT_HEX;
                            cnt_next   = fsip_pkg::CNT_W'(fsip_pkg::NHEX);
                        end
                    endcase
                end
            end
            fsip_pkg::ENG_DABBLE:
            begin
                digit_next = {dabbled[fsip_pkg::SR_W-2:0], bin_reg[fsip_pkg::WORD_BITS-1]};
                bin_next   = bin_reg << 1;
                if (cnt_one)
                begin
                    cnt_next = fsip_pkg::CNT_W'(fsip_pkg::NDEC);
                end
                else
                begin
                    cnt_next = cnt_reg - fsip_pkg::CNT_W'(1);
                end
            end
            fsip_pkg::ENG_DIGITS:
            begin
                if (step)
                begin
                    digit_next   = digit_shifted;
                    cnt_next     = cnt_reg - fsip_pkg::CNT_W'(1);
                    started_next = started_reg | show;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fsip_pkg::ENG_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            radix_reg   <= fsip_pkg::RADIX_DEC;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            radix_reg   <= radix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        bin_reg   <= bin_next;
    end

endmodule

FILE: hw/rtl/format_string_integer_printer_core.sv
// ----------------------------------------------------------------------------
// format_string_integer_printer_core: printf-style integer formatter
// Takes format bytes with an argument word and emits the formatted text one
// character per output beat.
// ----------------------------------------------------------------------------
// One format byte is taken per input beat, with its argument word. Plain
// bytes are echoed, '%' opens a conversion, and the next byte selects %%, %c,
// %d, %u, %b, %o, %x or %X; any other byte comes back as one beat with
// bad_format set. The last beat caused by a byte carries last; a lone '%'
// causes none. A new byte is taken only after every beat of the previous one
// has been placed in the output register. Binary, octal and hex move the
// digit shift register one digit per cycle while the output can take it,
// across every digit position of the word (32, 11 or 8 for a 32-bit word),
// skipped leading zeros included. Decimal first runs the bit-serial
// double-dabble over all WORD_BITS bits, then steps through NDEC digit
// positions. The minus sign is loaded into the output register in the same
// cycle that starts the conversion, so it does not hold up the digits.
// ----------------------------------------------------------------------------
module format_string_integer_printer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last,
    output logic        bad_format
);

    fsip_pkg::ctrl_state_t state_reg, state_next;
    logic                  pct_reg, pct_next;
    logic [7:0]            fmt_reg;
    fsip_pkg::word_t       word_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  last_reg, last_next;
    logic                  bad_reg, bad_next;

    logic                  need_emit;
    logic                  need_num;
    logic [7:0]            emit_ch;
    logic                  emit_last;
    logic                  emit_bad;
    logic                  slot_free;
    logic                  advance;

    fsip_pkg::num_cmd_t    num_cmd;
    logic                  cmd_valid;
    logic                  cmd_ready;
    fsip_pkg::num_beat_t   num_beat;
    logic                  beat_valid;
    logic                  beat_ready;

    fsip_num_engine u_num_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (num_cmd),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (num_beat)
    );

    assign slot_free = !out_valid_reg || out_ready;

    // Decode of the held format byte.
    always_comb
    begin
        need_emit     = 1'b0;
        need_num      = 1'b0;
        emit_ch       = fmt_reg;
        emit_last     = 1'b1;
        emit_bad      = 1'b0;
        num_cmd.value = word_reg;
        num_cmd.radix = fsip_pkg::RADIX_DEC;
        if (!pct_reg)
        begin
            need_emit = (fmt_reg != fsip_pkg::CHAR_PERCENT);
        end
        else
        begin
            unique case (fmt_reg)
                fsip_pkg::CHAR_PERCENT:
                begin
                    need_emit = 1'b1;
                end
                fsip_pkg::CHAR_LC_C:
                begin
                    need_emit = 1'b1;
                    emit_ch   = word_reg[7:0];
                end
                fsip_pkg::CHAR_LC_D:
                begin
                    need_num = 1'b1;
                    if (word_reg[fsip_pkg::WORD_BITS-1])
                    begin
                        // The magnitude of the most negative word fits as unsigned.
                        need_emit     = 1'b1;
                        emit_ch       = fsip_pkg::CHAR_MINUS;
                        emit_last     = 1'b0;
                        num_cmd.value = '0 - word_reg;
                    end
                end
                fsip_pkg::CHAR_LC_U:
                begin
                    need_num = 1'b1;
                end
                fsip_pkg::CHAR_LC_B:
                begin
                    need_num      = 1'b1;
                    num_cmd.radix = fsip_pkg::RADIX_BIN;
                end
                fsip_pkg::CHAR_LC_O:
                begin
                    need_num      = 1'b1;
                    num_cmd.radix = fsip_pkg::RADIX_OCT;
                end
                fsip_pkg::CHAR_LC_X:
                begin
                    need_num      = 1'b1;
                    num_cmd.radix = fsip_pkg::RADIX_HEX_LO;
                end
                fsip_pkg::CHAR_UC_X:
                begin
                    need_num      = 1'b1;
                    num_cmd.radix = fsip_pkg::RADIX_HEX_UP;
                end
                default:
                begin
                    need_emit = 1'b1;
                    emit_bad  = 1'b1;
                end
            endcase
        end
    end

    assign advance = (state_reg == fsip_pkg::CTRL_DISPATCH) &&
                     (!need_emit || slot_free) && (!need_num || cmd_ready);

    // Outputs of the control path.
    always_comb
    begin
        in_ready   = (state_reg == fsip_pkg::CTRL_IDLE);
        cmd_valid  = (state_reg == fsip_pkg::CTRL_DISPATCH) && need_num &&
                     (!need_emit || slot_free);
        beat_ready = (state_reg == fsip_pkg::CTRL_NUMBER) && slot_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fsip_pkg::CTRL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fsip_pkg::CTRL_DISPATCH;
                end
            end
            fsip_pkg::CTRL_DISPATCH:
            begin
                if (advance)
                begin
                    state_next = need_num ? fsip_pkg::CTRL_NUMBER : fsip_pkg::CTRL_IDLE;
                end
            end
            fsip_pkg::CTRL_NUMBER:
            begin
                if (beat_valid && beat_ready && num_beat.last)
                begin
                    state_next = fsip_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = fsip_pkg::CTRL_IDLE;
            end
        endcase
    end

    // Percent tracking and the output register.
    always_comb
    begin
        pct_next       = pct_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        if (advance)
        begin
            pct_next = !pct_reg && (fmt_reg == fsip_pkg::CHAR_PERCENT);
        end
        if (advance && need_emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_ch;
            last_next      = emit_last;
            bad_next       = emit_bad;
        end
        else if (beat_valid && beat_ready)
        begin
            out_valid_next = 1'b1;
            out_char_next  = num_beat.ch;
            last_next      = num_beat.last;
            bad_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsip_pkg::CTRL_IDLE;
            pct_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pct_reg       <= pct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fmt_reg  <= fmt_char;
            word_reg <= fsip_pkg::WORD_BITS'(arg_value);
        end
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last       = last_reg;
    assign bad_format = bad_reg;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for format_string_integer_printer_core
// Feeds format bytes with argument words over the input channel. A predictor
// inside the bench tracks the percent state and builds the expected text.
// Every output beat is compared field by field with the oldest expected
// character. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CHAR_LC_S = 8'h73;
    localparam int TIMEOUT_NS = 20_000_000;
    localparam int TAIL_CYCLES = 60;
    localparam int DRAIN_LIMIT = 50_000;
    localparam int RANDOM_ITEMS = 304;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } text_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  fmt_char = 8'h00;
    logic [31:0] arg_value = 32'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        last;
    logic        bad_format;

    text_beat_t expected_text[$];
    bit         after_pct = 1'b0;
    int         errors = 0;
    int         items_sent = 0;
    int         beats_checked = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    int         stall_request = 0;
    int         stall_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int         pattern_age = 0;

    format_string_integer_printer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .fmt_char   (fmt_char),
        .arg_value  (arg_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last       (last),
        .bad_format (bad_format)
    );

    always #6 clk = ~clk;

    // Works out the text that one accepted format byte produces.
    function automatic void predict_text(input logic [7:0] ch, input logic [31:0] arg);
        fsip_pkg::word_t w;
        fsip_pkg::word_t radix;
        logic [7:0]      digits [0:63];
        logic [7:0]      single;
        int              nd;
        int              d;
        int              i;
        bit              is_number;
        bit              upper;
        bit              minus;
        bit              bad;
        bit              silent;
        w = fsip_pkg::word_t'(arg);
        radix = 10;
        single = ch;
        is_number = 1'b0;
        upper = 1'b0;
        minus = 1'b0;
        bad = 1'b0;
        silent = 1'b0;
        if (!after_pct)
        begin
            if (ch == fsip_pkg::CHAR_PERCENT)
            begin
                after_pct = 1'b1;
                silent = 1'b1;
            end
        end
        else
        begin
            after_pct = 1'b0;
            case (ch)
                fsip_pkg::CHAR_PERCENT: single = fsip_pkg::CHAR_PERCENT;
                fsip_pkg::CHAR_LC_C:    single = w[7:0];
                fsip_pkg::CHAR_LC_D:
                begin
                    is_number = 1'b1;
                    if (w[fsip_pkg::WORD_BITS-1])
                    begin
                        minus = 1'b1;
                        w = -w;
                    end
                end
                fsip_pkg::CHAR_LC_U:    is_number = 1'b1;
                fsip_pkg::CHAR_LC_B:
                begin
                    is_number = 1'b1;
                    radix = 2;
                end
                fsip_pkg::CHAR_LC_O:
                begin
                    is_number = 1'b1;
                    radix = 8;
                end
                fsip_pkg::CHAR_LC_X:
                begin
                    is_number = 1'b1;
                    radix = 16;
                end
                fsip_pkg::CHAR_UC_X:
                begin
                    is_number = 1'b1;
                    radix = 16;
                    upper = 1'b1;
                end
                default:                bad = 1'b1;
            endcase
        end
        if (!silent)
        begin
            if (minus)
                expected_text.push_back('{ch: fsip_pkg::CHAR_MINUS, last: 1'b0, bad: 1'b0});
            if (is_number)
            begin
                nd = 0;
                do
                begin
                    d = int'(w % radix);
                    if (d < 10)
                        digits[nd] = fsip_pkg::CHAR_ZERO + 8'(d);
                    else
                        digits[nd] = (upper ? fsip_pkg::CHAR_UC_A : fsip_pkg::CHAR_LC_A)
                                     + 8'(d - 10);
                    w = w / radix;
                    nd++;
                end while (w != 0);
                for (i = nd - 1; i >= 0; i--)
                    expected_text.push_back('{ch: digits[i], last: (i == 0), bad: 1'b0});
            end
            else
            begin
                expected_text.push_back('{ch: single, last: 1'b1, bad: bad});
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Sends one beat. Called at a rising edge; returns at the edge that took it.
    task automatic send_item(input logic [7:0] ch, input logic [31:0] arg);
        int gap;
        bit took;
        if (burst_left == 0)
        begin
            gap = 0;
            if (gaps_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid  <= 1'b1;
        fmt_char  <= ch;
        arg_value <= arg;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        predict_text(ch, arg);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_conversion(input logic [7:0] conv, input logic [31:0] arg);
        send_item(fsip_pkg::CHAR_PERCENT, $urandom);
        send_item(conv, arg);
    endtask

    // Always waits on a rising edge, so that valid is seen low there.
    task automatic wait_drained();
        int waited;
        in_valid <= 1'b0;
        burst_left = 0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end while (expected_text.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'(1) << $urandom_range(0, 31);
            4:       return $urandom_range(0, 255);
            5:       return -($urandom_range(1, 1000));
            default: return $urandom;
        endcase
    endfunction

    // Output side: a pattern of its own, or a long hold when one is asked.
    always @(posedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom) | 16'h0001;
                    2:       ready_pattern = 16'($urandom | $urandom) | 16'h0001;
                    default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
                endcase
                pattern_age = $urandom_range(20, 200);
            end
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_age--;
        end
    end

    // A beat seen valid and ready here is taken at the next rising edge.
    always @(negedge clk)
    begin : check_text
        text_beat_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat char 0x%02h", out_char));
            end
            else
            begin
                want = expected_text.pop_front();
                beats_checked++;
                if (out_char !== want.ch)
                    report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                              out_char, want.ch));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b on char 0x%02h",
                                              last, want.last, want.ch));
                if (bad_format !== want.bad)
                    report_mismatch($sformatf("bad_format %b, expected %b on char 0x%02h",
                                              bad_format, want.bad, want.ch));
            end
        end
    end

    task automatic test_literals();
        send_item(8'h00, 32'hFFFF_FFFF);
        send_item(8'hFF, 32'h0000_0000);
    endtask

    task automatic test_conversions();
        send_conversion(fsip_pkg::CHAR_PERCENT, 32'h1234_5678);
        send_conversion(fsip_pkg::CHAR_LC_C, 32'hFFFF_FF41);
        send_conversion(fsip_pkg::CHAR_LC_D, 32'h0000_0000);
        // The most negative word prints its full magnitude.
        send_conversion(fsip_pkg::CHAR_LC_D, 32'h8000_0000);
        send_conversion(fsip_pkg::CHAR_LC_D, 32'h7FFF_FFFF);
        send_conversion(fsip_pkg::CHAR_LC_U, 32'hFFFF_FFFF);
        send_conversion(fsip_pkg::CHAR_LC_B, 32'hFFFF_FFFF);
        send_conversion(fsip_pkg::CHAR_LC_O, 32'hFFFF_FFFF);
        send_conversion(fsip_pkg::CHAR_LC_X, 32'hDEAD_BEEF);
        send_conversion(fsip_pkg::CHAR_UC_X, 32'hDEAD_BEEF);
    endtask

    task automatic test_bad_conversions();
        send_conversion(CHAR_LC_S, 32'h0);
        send_conversion(8'h00, 32'hFFFF_FFFF);
    endtask

    // Hold the output off while long conversions keep coming in.
    task automatic test_backpressure();
        int i;
        wait_drained();
        stall_request = 400;
        gaps_on = 1'b0;
        for (i = 0; i < 12; i++)
            send_conversion((i % 2 == 0) ? fsip_pkg::CHAR_LC_B : fsip_pkg::CHAR_LC_D,
                            pick_arg());
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // Pause the input in every phase of a conversion until the output is empty.
    task automatic test_paused_input();
        send_item(fsip_pkg::CHAR_PERCENT, $urandom);
        wait_drained();
        send_item(fsip_pkg::CHAR_LC_D, 32'hFFFF_FFFF);
        wait_drained();
        send_item(fsip_pkg::CHAR_UC_A, $urandom);
        send_item(fsip_pkg::CHAR_PERCENT, $urandom);
        wait_drained();
        send_item(fsip_pkg::CHAR_UC_A, $urandom);
        wait_drained();
    endtask

    task automatic test_random_text();
        int sent_here;
        int kind;
        logic [7:0] ch;
        sent_here = 0;
        while (sent_here < RANDOM_ITEMS)
        begin
            if (sent_here % 60 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                ch = 8'($urandom);
                if (ch == fsip_pkg::CHAR_PERCENT)
                    ch = fsip_pkg::CHAR_LC_A;
                send_item(ch, $urandom);
                sent_here++;
            end
            else if (kind < 80)
            begin
                case ($urandom_range(0, 7))
                    0:       ch = fsip_pkg::CHAR_PERCENT;
                    1:       ch = fsip_pkg::CHAR_LC_C;
                    2:       ch = fsip_pkg::CHAR_LC_D;
                    3:       ch = fsip_pkg::CHAR_LC_U;
                    4:       ch = fsip_pkg::CHAR_LC_B;
                    5:       ch = fsip_pkg::CHAR_LC_O;
                    6:       ch = fsip_pkg::CHAR_LC_X;
                    default: ch = fsip_pkg::CHAR_UC_X;
                endcase
                send_conversion(ch, pick_arg());
                sent_here += 2;
            end
            else if (kind < 92)
            begin
                send_conversion(8'($urandom), pick_arg());
                sent_here += 2;
            end
            else
            begin
                // A stray percent: whatever comes next is taken as a conversion.
                send_item(fsip_pkg::CHAR_PERCENT, $urandom);
                sent_here++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_literals();
        test_conversions();
        test_bad_conversions();
        test_backpressure();
        test_paused_input();
        test_random_text();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
            report_mismatch($sformatf("%0d expected chars never came out",
                                      expected_text.size()));

        $display("summary: %0d format bytes sent, %0d output beats checked",
                 items_sent, beats_checked);
        $display("summary: all conversions, bad conversions, stray percents, long stalls");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d chars still expected", expected_text.size());
        $display("testbench: errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fsip_pkg.sv
hw/rtl/fsip_num_engine.sv
hw/rtl/format_string_integer_printer_core.sv
tb/testbench.sv
